// File: hw/rtl/size_class_block_allocator_top_assert.svh
// assertion macros for the size class block allocator
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define SCBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the following clock
`define SCBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/scba_pkg.sv
// shared types, constants and helpers of the size class block allocator
package scba_pkg;
    localparam int ADDR_BITS   = 16;
    localparam int SLOT_BITS   = ADDR_BITS - 3;
    localparam int LINK_BITS   = SLOT_BITS + 1;
    localparam int NUM_CLASSES = 8;
    localparam int CLS_BITS    = 3;
    localparam int HDR_BITS    = 15 + LINK_BITS;
    localparam int SPACE_BITS  = 18;
    localparam int CNT_BITS    = 12;
    localparam int HEADER_BYTES = 8;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_STATS = 2'd2;
    localparam logic [1:0] OP_INIT  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERSIZE = 3'd1;
    localparam logic [2:0] ST_NO_ROOM  = 3'd2;
    localparam logic [2:0] ST_NOT_USED = 3'd3;
    localparam logic [2:0] ST_UNINIT   = 3'd4;

    localparam logic [2:0] CFG_R0_START = 3'd0;
    localparam logic [2:0] CFG_R0_SIZE  = 3'd1;
    localparam logic [2:0] CFG_R1_START = 3'd2;
    localparam logic [2:0] CFG_R1_SIZE  = 3'd3;
    localparam logic [2:0] CFG_COUNT    = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_size;
        logic [15:0] block_address;
        logic [3:0]  class_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] payload_address;
        logic [17:0] free_bytes;
        logic [17:0] min_free_bytes;
        logic [17:0] uncarved_bytes;
        logic [16:0] primary_uncarved_bytes;
        logic [11:0] class_carved_count;
        logic [11:0] class_free_count;
        logic [12:0] class_block_size;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [16:0] data;
    } t_cfg_item;

    // controller to datapath
    typedef struct packed {
        logic start;     // latch item, decode
        logic rd_issue;  // header read address valid
        logic commit;    // apply update, build result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_read;
    } t_dp_sts;

    // payload bytes of each class
    function automatic logic [12:0] class_size(input logic [CLS_BITS-1:0] c);
        case (c)
            3'd0: class_size = 13'd16;
            3'd1: class_size = 13'd32;
            3'd2: class_size = 13'd64;
            3'd3: class_size = 13'd128;
            3'd4: class_size = 13'd256;
            3'd5: class_size = 13'd1024;
            3'd6: class_size = 13'd2048;
            default: class_size = 13'd4096;
        endcase
    endfunction

    // smallest class holding the given byte count
    function automatic logic [CLS_BITS:0] class_for(input logic [16:0] bytes);
        logic [CLS_BITS:0] r;
        r = {1'b1, 3'd0};
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ({4'd0, class_size(CLS_BITS'(c))} >= bytes) r = {1'b0, CLS_BITS'(c)};
        end
        return r;
    endfunction
endpackage

// File: hw/rtl/scba_if.sv
// valid/ready channel carrying one payload beat
interface scba_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/scba_ram.sv
// generic single port RAM with registered read
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write the addressed word when enabled and always register its old contents for read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/scba_ctrl.sv
// controller sequencing accept, header read, commit and result beat
module scba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output scba_pkg::t_dp_cmd o_cmd,
    input  scba_pkg::t_dp_sts i_sts
);
    import scba_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_DONE} t_state;
    t_state r_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   can_commit;

    // accept when idle; the result register holds the previous beat meanwhile
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // commit only once the result register is free or being emptied
    assign can_commit = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.start    = i_in_valid && o_in_ready;
        o_cmd.rd_issue = (r_state == S_READ);
        o_cmd.commit   = (r_state == S_DONE) && can_commit;
    end

    // next result valid
    always_comb begin
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: if (o_cmd.start) r_state <= S_READ;
                S_READ: r_state <= i_sts.need_read ? S_WAIT : S_DONE;
                S_WAIT: r_state <= S_DONE;
                S_DONE: if (can_commit) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/scba_dp.sv
// datapath: free lists, region cursors, space figures, header memory
module scba_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scba_pkg::t_dp_cmd  i_cmd,
    output scba_pkg::t_dp_sts  o_sts,
    input  scba_pkg::t_in_item i_item,
    input  logic               i_cfg_we,
    input  scba_pkg::t_cfg_item i_cfg,
    output scba_pkg::t_out_item o_result
);
    import scba_pkg::*;

    // configuration
    logic [15:0] r_cfg_start [2];
    logic [16:0] r_cfg_size [2];
    logic [1:0]  r_cfg_count;

    // allocator state
    logic [LINK_BITS-1:0]  r_head [NUM_CLASSES];
    logic [CNT_BITS-1:0]   r_free_cnt [NUM_CLASSES];
    logic [CNT_BITS-1:0]   r_carv_cnt [NUM_CLASSES];
    logic [ADDR_BITS-1:0]  r_cursor [2];
    logic [16:0]           r_remain [2];
    logic [SPACE_BITS-1:0] r_free, r_min, r_uncarved;
    logic [16:0]           r_prim;
    logic                  r_init;

    t_in_item  r_item;
    t_out_item r_result;

    // decoded item
    logic [CLS_BITS:0]   cls_req;
    logic [CLS_BITS-1:0] cls;
    logic [12:0]         need;
    logic                pop;
    logic                r0_fit, r1_fit;
    logic [SLOT_BITS-1:0] free_slot, rd_slot;

    // memory port
    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_addr;
    logic [HDR_BITS-1:0]  mem_wdata, mem_rdata;

    scba_ram #(.WIDTH(HDR_BITS), .DEPTH(1 << SLOT_BITS)) u_hdr (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    assign cls_req   = class_for({1'b0, r_item.request_size});
    assign cls       = cls_req[CLS_BITS-1:0];
    assign need      = class_size(cls) + 13'(HEADER_BYTES);
    assign pop       = r_head[cls][LINK_BITS-1];
    assign r0_fit    = (r_cfg_count != 2'd0) && (r_remain[0] >= {4'd0, need});
    assign r1_fit    = (r_cfg_count >= 2'd2) && (r_remain[1] >= {4'd0, need});
    assign free_slot = SLOT_BITS'((r_item.block_address - 16'(HEADER_BYTES)) >> 3);
    assign rd_slot   = (r_item.opcode == OP_ALLOC) ? r_head[cls][SLOT_BITS-1:0] : free_slot;

    assign o_sts.need_read = r_init && ((r_item.opcode == OP_FREE) ||
        (r_item.opcode == OP_ALLOC && !cls_req[CLS_BITS] && pop));

    // free header decode
    logic [12:0]          h_size;
    logic                 h_used;
    logic [CLS_BITS:0]    h_cls_req;
    logic [CLS_BITS-1:0]  h_cls;
    logic                 free_ok;
    assign h_size    = mem_rdata[12:0];
    assign h_used    = mem_rdata[13];
    assign h_cls_req = class_for({4'd0, h_size - 13'(HEADER_BYTES)});
    assign h_cls     = h_cls_req[CLS_BITS-1:0];
    assign free_ok   = (r_item.block_address[2:0] == 3'd0) && h_used &&
                       (h_size >= 13'(HEADER_BYTES)) && !h_cls_req[CLS_BITS];

    // memory control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = rd_slot;
        mem_wdata = mem_rdata;
        if (i_cmd.commit && r_init && r_item.opcode == OP_ALLOC && !cls_req[CLS_BITS]) begin
            if (pop) begin
                mem_we    = 1'b1;
                mem_wdata = {{LINK_BITS{1'b0}}, mem_rdata[14], 1'b1, mem_rdata[12:0]};
            end else if (r0_fit || r1_fit) begin
                mem_we    = 1'b1;
                mem_addr  = SLOT_BITS'((r0_fit ? r_cursor[0] : r_cursor[1]) >> 3);
                mem_wdata = {{LINK_BITS{1'b0}}, !r0_fit, 1'b1, need};
            end
        end else if (i_cmd.commit && r_init && r_item.opcode == OP_FREE && free_ok) begin
            mem_we    = 1'b1;
            mem_wdata = {r_head[h_cls], mem_rdata[14], 1'b0, mem_rdata[12:0]};
        end
    end

    // free space after the operation at commit; allocations also lower the low water mark with it
    logic [SPACE_BITS-1:0] n_free;

    // state update
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_item <= i_item;
        if (!i_rst_n) begin
            r_cfg_start[0] <= '0; r_cfg_start[1] <= '0;
            r_cfg_size[0] <= '0;  r_cfg_size[1] <= '0;
            r_cfg_count <= '0;
            r_init <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0; r_free_cnt[c] <= '0; r_carv_cnt[c] <= '0;
            end
            r_cursor[0] <= '0; r_cursor[1] <= '0;
            r_remain[0] <= '0; r_remain[1] <= '0;
            r_free <= '0; r_min <= '0; r_uncarved <= '0; r_prim <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg.index)
                    CFG_R0_START: r_cfg_start[0] <= {i_cfg.data[15:3], 3'd0};
                    CFG_R0_SIZE:  r_cfg_size[0] <= i_cfg.data;
                    CFG_R1_START: r_cfg_start[1] <= {i_cfg.data[15:3], 3'd0};
                    CFG_R1_SIZE:  r_cfg_size[1] <= i_cfg.data;
                    CFG_COUNT:    r_cfg_count <= i_cfg.data[1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                if (r_item.opcode == OP_INIT) begin
                    if (!r_init) begin
                        r_init <= 1'b1;
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                            r_head[c] <= '0; r_free_cnt[c] <= '0; r_carv_cnt[c] <= '0;
                        end
                        r_cursor[0] <= (r_cfg_count != 2'd0) ? r_cfg_start[0] : 16'd0;
                        r_remain[0] <= (r_cfg_count != 2'd0) ? r_cfg_size[0] : 17'd0;
                        r_cursor[1] <= (r_cfg_count >= 2'd2) ? r_cfg_start[1] : 16'd0;
                        r_remain[1] <= (r_cfg_count >= 2'd2) ? r_cfg_size[1] : 17'd0;
                        r_free     <= n_free;
                        r_min      <= n_free;
                        r_uncarved <= n_free;
                        r_prim     <= (r_cfg_count != 2'd0) ? r_cfg_size[0] : 17'd0;
                    end
                end else if (r_init && r_item.opcode == OP_ALLOC && !cls_req[CLS_BITS]) begin
                    if (pop) begin
                        r_head[cls]     <= mem_rdata[HDR_BITS-1:15];
                        r_free_cnt[cls] <= r_free_cnt[cls] - 1'b1;
                        r_free          <= n_free;
                        if (n_free < r_min) r_min <= n_free;
                    end else if (r0_fit || r1_fit) begin
                        if (r0_fit) begin
                            r_cursor[0] <= r_cursor[0] + {3'd0, need};
                            r_remain[0] <= r_remain[0] - {4'd0, need};
                            r_prim      <= r_prim - {4'd0, need};
                        end else begin
                            r_cursor[1] <= r_cursor[1] + {3'd0, need};
                            r_remain[1] <= r_remain[1] - {4'd0, need};
                        end
                        r_carv_cnt[cls] <= r_carv_cnt[cls] + 1'b1;
                        r_free          <= n_free;
                        if (n_free < r_min) r_min <= n_free;
                        r_uncarved      <= r_uncarved - {5'd0, need};
                    end
                end else if (r_init && r_item.opcode == OP_FREE && free_ok) begin
                    r_head[h_cls]     <= {1'b1, free_slot};
                    r_free_cnt[h_cls] <= r_free_cnt[h_cls] + 1'b1;
                    r_free            <= n_free;
                end
            end
        end
    end

    // next free figure for the operation at commit
    always_comb begin
        if (r_item.opcode == OP_INIT)
            n_free = ((r_cfg_count != 2'd0) ? {1'b0, r_cfg_size[0]} : 18'd0) +
                     ((r_cfg_count >= 2'd2) ? {1'b0, r_cfg_size[1]} : 18'd0);
        else if (r_item.opcode == OP_FREE)
            n_free = r_free + {5'd0, h_size};
        else if (pop)
            n_free = r_free - {5'd0, h_size};
        else
            n_free = r_free - {5'd0, need};
    end

    // result status and payload, built from the state at commit, before its update
    logic [2:0]  n_status;
    logic [15:0] n_payload;
    always_comb begin
        n_status  = ST_OK;
        n_payload = '0;
        if (r_item.opcode == OP_INIT) n_status = ST_OK;
        else if (!r_init) n_status = ST_UNINIT;
        else if (r_item.opcode == OP_ALLOC) begin
            if (cls_req[CLS_BITS]) n_status = ST_OVERSIZE;
            else if (pop) n_payload = {r_head[cls][SLOT_BITS-1:0], 3'd0} + 16'(HEADER_BYTES);
            else if (r0_fit) n_payload = r_cursor[0] + 16'(HEADER_BYTES);
            else if (r1_fit) n_payload = r_cursor[1] + 16'(HEADER_BYTES);
            else n_status = ST_NO_ROOM;
        end else if (r_item.opcode == OP_FREE) begin
            if (!free_ok) n_status = ST_NOT_USED;
        end
    end

    logic r_fill;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fill <= 1'b0;
        else r_fill <= i_cmd.commit;
        if (i_cmd.commit) begin
            r_result.status          <= n_status;
            r_result.payload_address <= n_payload;
        end
        if (r_fill) begin
            r_result.free_bytes             <= r_free;
            r_result.min_free_bytes         <= r_min;
            r_result.uncarved_bytes         <= r_uncarved;
            r_result.primary_uncarved_bytes <= r_prim;
            if (!r_item.class_index[3]) begin
                r_result.class_carved_count <= r_carv_cnt[r_item.class_index[2:0]];
                r_result.class_free_count   <= r_free_cnt[r_item.class_index[2:0]];
                r_result.class_block_size   <= class_size(r_item.class_index[2:0]);
            end else begin
                r_result.class_carved_count <= '0;
                r_result.class_free_count   <= '0;
                r_result.class_block_size   <= '0;
            end
        end
    end

    // figures register in the cycle after commit; meanwhile they pass straight from the state to the output
    always_comb begin
        o_result = r_result;
        if (r_fill) begin
            o_result.free_bytes             = r_free;
            o_result.min_free_bytes         = r_min;
            o_result.uncarved_bytes         = r_uncarved;
            o_result.primary_uncarved_bytes = r_prim;
            o_result.class_carved_count = r_item.class_index[3] ? 12'd0 :
                                          r_carv_cnt[r_item.class_index[2:0]];
            o_result.class_free_count   = r_item.class_index[3] ? 12'd0 :
                                          r_free_cnt[r_item.class_index[2:0]];
            o_result.class_block_size   = r_item.class_index[3] ? 13'd0 :
                                          class_size(r_item.class_index[2:0]);
        end
    end
endmodule

// File: hw/rtl/size_class_block_allocator_top.sv
// top level of the size class block allocator
//  channel   direction  payload
//  in        sink       opcode, request_size, block_address, class_index
//  out       source     status, payload_address, space figures, class statistics
//  cfg       sink       register index, write data
// an item goes from accept through read issue, then a wait for the memory read
// when a header is read, to commit; the single header RAM port sets this
// the next beat is accepted once the item commits; a result still waiting in the
// result register holds off the next commit
// synchronous active low reset clears lists, counters and the initialized flag
// header memory is not cleared; configuration writes are taken at any time
module size_class_block_allocator_top (
    input  logic i_clk,
    input  logic i_rst_n,
    scba_if.sink   in_ch,
    scba_if.source out_ch,
    scba_if.sink   cfg_ch
);
    import scba_pkg::*;
    `include "size_class_block_allocator_top_assert.svh"

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    out_valid;

    assign cfg_ch.ready = 1'b1;

    scba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_valid),
        .i_out_ready(out_ch.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    scba_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_item  (in_ch.data),
        .i_cfg_we(cfg_ch.valid),
        .i_cfg   (cfg_ch.data),
        .o_result(out_ch.data)
    );

    assign out_ch.valid = out_valid;

    `SCBA_ASSERT_NEXT(a_hold_result, out_valid && !out_ch.ready, out_valid, "result dropped")
    `SCBA_ASSERT_NEXT(a_commit_gives_valid, cmd.commit, out_valid, "commit without result")
    `SCBA_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.start, cmd.rd_issue, cmd.commit}),
        "overlapping commands")
endmodule
